>>> rtl/core/nnsag_pkg.sv
// shared types, register map and constants for the scaling address sequencer
package nnsag_pkg;

  // register field widths, fixed by the register map
  localparam int SRC_DIM_REG_W = 12;
  localparam int STRIDE_REG_W  = 13;
  localparam int BASE_REG_W    = 24;
  localparam int DST_DIM_REG_W = 11;

  // result address field width on the stream
  localparam int OUT_ADDR_W = 24;

  // configuration port geometry
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_IDX_W  = 3;

  // default parameter values
  localparam int DEF_ADDR_BITS   = 24;
  localparam int DEF_MAX_SRC_DIM = 2048;
  localparam int DEF_MAX_DST_DIM = 1024;

  // register indexes (byte address is 4 * index)
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_STRIDE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_BASE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DST_BASE   = 3'd6;

  // register reset values
  localparam logic [SRC_DIM_REG_W-1:0] RST_SRC_WIDTH  = 12'd320;
  localparam logic [SRC_DIM_REG_W-1:0] RST_SRC_HEIGHT = 12'd240;
  localparam logic [STRIDE_REG_W-1:0]  RST_SRC_STRIDE = 13'd320;
  localparam logic [BASE_REG_W-1:0]    RST_SRC_BASE   = 24'd0;
  localparam logic [DST_DIM_REG_W-1:0] RST_DST_WIDTH  = 11'd320;
  localparam logic [DST_DIM_REG_W-1:0] RST_DST_HEIGHT = 11'd200;
  localparam logic [BASE_REG_W-1:0]    RST_DST_BASE   = 24'd0;

  // sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_STEP
  } state_t;

  // commands from the sequencer to the error stepper
  typedef struct packed {
    logic clear;   // zero the stepper errors and positions
    logic start;   // load a new error sum and begin stepping
    logic axis_y;  // with start: vertical stepper, else horizontal
    logic run;     // one subtract step allowed this cycle
  } step_cmd_t;

endpackage

>>> rtl/core/nearest_neighbor_scale_address_gen.sv
// top level of the nearest-neighbor scaling address sequencer
//
//  channel  direction  handshake            payload
//  in_      slave      in_tvalid/in_tready  tdata[0] restart
//  out_     master     out_tvalid/tready    tdata src/dst address, tlast row end,
//                                            tuser frame end
//  cfg_     apb slave  psel/penable/pready  seven registers at 4 * index
//
//  a word is taken while idle and the output register is empty or being
//  drained; the result sits in an output register. unless the word ends the
//  frame, the sequencer then stays in the step state while the shared
//  subtractor makes the source steps it causes (source columns at a pixel,
//  source rows at a row end), and returns to idle when no step is left.
//  reset (synchronous, active low) clears all counters and loads the register reset values.
module nearest_neighbor_scale_address_gen #(
  parameter int ADDR_BITS   = nnsag_pkg::DEF_ADDR_BITS,
  parameter int MAX_SRC_DIM = nnsag_pkg::DEF_MAX_SRC_DIM,
  parameter int MAX_DST_DIM = nnsag_pkg::DEF_MAX_DST_DIM
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input words
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [7:0]                          in_tdata,     // [0] restart
  // result words
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [47:0]                         out_tdata,    // [23:0] src_address,
                                                            // [47:24] dst_address
  output logic                                out_tlast,    // row_end
  output logic [0:0]                          out_tuser,    // [0] frame_end
  // configuration
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [nnsag_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [nnsag_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [nnsag_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                                cfg_pready
);

  localparam int DW   = $clog2(MAX_DST_DIM + 1);
  localparam int SW   = $clog2(MAX_SRC_DIM + 1);
  localparam int DCW  = $clog2(MAX_DST_DIM);
  localparam int OAW  = nnsag_pkg::OUT_ADDR_W;
  localparam int AEXT = (ADDR_BITS > OAW) ? ADDR_BITS : OAW;

  // configuration registers
  logic [nnsag_pkg::SRC_DIM_REG_W-1:0] src_width_r, src_height_r;
  logic [nnsag_pkg::STRIDE_REG_W-1:0]  src_stride_r;
  logic [nnsag_pkg::BASE_REG_W-1:0]    src_base_r, dst_base_r;
  logic [nnsag_pkg::DST_DIM_REG_W-1:0] dst_width_r, dst_height_r;
  logic                                cfg_wr;
  logic [nnsag_pkg::CFG_IDX_W-1:0]     cfg_idx;

  // sequencer and destination counters
  nnsag_pkg::state_t    state_r, state_nxt;
  logic [DCW-1:0]       dst_col_r, dst_col_nxt;
  logic [DCW-1:0]       dst_row_r, dst_row_nxt;
  logic [ADDR_BITS-1:0] dst_off_r, dst_off_nxt;

  // output register
  logic                 out_valid_r, out_valid_nxt;
  logic [OAW-1:0]       src_addr_r, dst_addr_r;
  logic                 row_end_r, frame_end_r;

  // datapath
  logic                 accept, restart;
  logic [DW-1:0]        w_eff, h_eff;
  logic [SW-1:0]        sw_eff, sh_eff;
  logic [DCW-1:0]       col_eff, row_eff;
  logic [ADDR_BITS-1:0] off_eff, scol_eff, srow_eff;
  logic [ADDR_BITS-1:0] src_sum, dst_sum;
  logic [AEXT-1:0]      src_ext, dst_ext;
  logic                 row_end, frame_end;
  logic [ADDR_BITS-1:0] src_col, src_row_base;
  logic                 step_done;
  nnsag_pkg::step_cmd_t cmd;

  // apb register writes
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[nnsag_pkg::CFG_ADDR_W-1:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= nnsag_pkg::RST_SRC_WIDTH;
      src_height_r <= nnsag_pkg::RST_SRC_HEIGHT;
      src_stride_r <= nnsag_pkg::RST_SRC_STRIDE;
      src_base_r   <= nnsag_pkg::RST_SRC_BASE;
      dst_width_r  <= nnsag_pkg::RST_DST_WIDTH;
      dst_height_r <= nnsag_pkg::RST_DST_HEIGHT;
      dst_base_r   <= nnsag_pkg::RST_DST_BASE;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        nnsag_pkg::REG_SRC_WIDTH:  src_width_r  <= cfg_pwdata[nnsag_pkg::SRC_DIM_REG_W-1:0];
        nnsag_pkg::REG_SRC_HEIGHT: src_height_r <= cfg_pwdata[nnsag_pkg::SRC_DIM_REG_W-1:0];
        nnsag_pkg::REG_SRC_STRIDE: src_stride_r <= cfg_pwdata[nnsag_pkg::STRIDE_REG_W-1:0];
        nnsag_pkg::REG_SRC_BASE:   src_base_r   <= cfg_pwdata[nnsag_pkg::BASE_REG_W-1:0];
        nnsag_pkg::REG_DST_WIDTH:  dst_width_r  <= cfg_pwdata[nnsag_pkg::DST_DIM_REG_W-1:0];
        nnsag_pkg::REG_DST_HEIGHT: dst_height_r <= cfg_pwdata[nnsag_pkg::DST_DIM_REG_W-1:0];
        nnsag_pkg::REG_DST_BASE:   dst_base_r   <= cfg_pwdata[nnsag_pkg::BASE_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // apb register reads
  always_comb begin
    unique case (cfg_idx)
      nnsag_pkg::REG_SRC_WIDTH:  cfg_prdata = nnsag_pkg::CFG_DATA_W'(src_width_r);
      nnsag_pkg::REG_SRC_HEIGHT: cfg_prdata = nnsag_pkg::CFG_DATA_W'(src_height_r);
      nnsag_pkg::REG_SRC_STRIDE: cfg_prdata = nnsag_pkg::CFG_DATA_W'(src_stride_r);
      nnsag_pkg::REG_SRC_BASE:   cfg_prdata = nnsag_pkg::CFG_DATA_W'(src_base_r);
      nnsag_pkg::REG_DST_WIDTH:  cfg_prdata = nnsag_pkg::CFG_DATA_W'(dst_width_r);
      nnsag_pkg::REG_DST_HEIGHT: cfg_prdata = nnsag_pkg::CFG_DATA_W'(dst_height_r);
      nnsag_pkg::REG_DST_BASE:   cfg_prdata = nnsag_pkg::CFG_DATA_W'(dst_base_r);
      default:                   cfg_prdata = '0;
    endcase
  end

  // clamped frame dimensions
  assign w_eff  = (dst_width_r == '0) ? DW'(1) :
                  (32'(dst_width_r) > 32'(MAX_DST_DIM)) ? DW'(MAX_DST_DIM) : DW'(dst_width_r);
  assign h_eff  = (dst_height_r == '0) ? DW'(1) :
                  (32'(dst_height_r) > 32'(MAX_DST_DIM)) ? DW'(MAX_DST_DIM) : DW'(dst_height_r);
  assign sw_eff = (32'(src_width_r) > 32'(MAX_SRC_DIM)) ? SW'(MAX_SRC_DIM) : SW'(src_width_r);
  assign sh_eff = (32'(src_height_r) > 32'(MAX_SRC_DIM)) ? SW'(MAX_SRC_DIM) : SW'(src_height_r);

  // counters as seen by this word, after an optional restart
  assign restart  = in_tdata[0];
  assign col_eff  = restart ? '0 : dst_col_r;
  assign row_eff  = restart ? '0 : dst_row_r;
  assign off_eff  = restart ? '0 : dst_off_r;
  assign scol_eff = restart ? '0 : src_col;
  assign srow_eff = restart ? '0 : src_row_base;

  // row and frame marks
  assign row_end   = 32'(col_eff) >= (32'(w_eff) - 32'd1);
  assign frame_end = row_end && (32'(row_eff) >= (32'(h_eff) - 32'd1));

  // addresses, wrapped to the address width
  assign src_sum = ADDR_BITS'(src_base_r) + srow_eff + scol_eff;
  assign dst_sum = ADDR_BITS'(dst_base_r) + off_eff;
  assign src_ext = AEXT'(src_sum);
  assign dst_ext = AEXT'(dst_sum);

  // sequencer: next state and handshake
  always_comb begin
    state_nxt  = state_r;
    in_tready  = 1'b0;
    cmd        = '0;
    unique case (state_r)
      nnsag_pkg::ST_IDLE: begin
        in_tready = !out_valid_r || out_tready;
        if (in_tvalid && in_tready) begin
          cmd.clear  = restart || frame_end;
          cmd.start  = !frame_end;
          cmd.axis_y = row_end;
          if (!frame_end) begin
            state_nxt = nnsag_pkg::ST_STEP;
          end
        end
      end
      nnsag_pkg::ST_STEP: begin
        cmd.run = 1'b1;
        if (step_done) begin
          state_nxt = nnsag_pkg::ST_IDLE;
        end
      end
      default: state_nxt = nnsag_pkg::ST_IDLE;
    endcase
  end

  assign accept = in_tvalid && in_tready;

  // destination counters
  always_comb begin
    dst_col_nxt = dst_col_r;
    dst_row_nxt = dst_row_r;
    dst_off_nxt = dst_off_r;
    if (accept) begin
      if (frame_end) begin
        dst_col_nxt = '0;
        dst_row_nxt = '0;
        dst_off_nxt = '0;
      end else begin
        dst_off_nxt = off_eff + ADDR_BITS'(1);
        if (row_end) begin
          dst_col_nxt = '0;
          dst_row_nxt = row_eff + DCW'(1);
        end else begin
          dst_col_nxt = col_eff + DCW'(1);
          dst_row_nxt = row_eff;
        end
      end
    end
  end

  // output register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nnsag_pkg::ST_IDLE;
      dst_col_r   <= '0;
      dst_row_r   <= '0;
      dst_off_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dst_col_r   <= dst_col_nxt;
      dst_row_r   <= dst_row_nxt;
      dst_off_r   <= dst_off_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      src_addr_r  <= src_ext[OAW-1:0];
      dst_addr_r  <= dst_ext[OAW-1:0];
      row_end_r   <= row_end;
      frame_end_r <= frame_end;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {dst_addr_r, src_addr_r};
  assign out_tlast  = row_end_r;
  assign out_tuser  = frame_end_r;

  // error steppers with the shared subtractor
  nnsag_stepper #(
    .ADDR_BITS   (ADDR_BITS),
    .MAX_SRC_DIM (MAX_SRC_DIM),
    .MAX_DST_DIM (MAX_DST_DIM)
  ) u_stepper (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .src_w        (sw_eff),
    .src_h        (sh_eff),
    .dst_w        (w_eff),
    .dst_h        (h_eff),
    .stride       (src_stride_r),
    .src_col      (src_col),
    .src_row_base (src_row_base),
    .done         (step_done)
  );

`ifndef NO_ASSERTIONS
  // a frame-end word leaves all destination counters at zero
  a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && frame_end) |=> (dst_col_r == '0 && dst_row_r == '0 && dst_off_r == '0))
    else $error("counters not cleared after frame end");

  // every accepted word shows up in the output register
  a_out_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted word produced no result");

  // a row end moves to column zero of the next row
  a_row_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && row_end && !frame_end)
      |=> (dst_col_r == '0 && dst_row_r == $past(row_eff) + DCW'(1)))
    else $error("row end did not advance the destination row");

  // no word is taken while the stepper is running
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !frame_end) |=> !in_tready)
    else $error("word accepted while stepping");
`endif

endmodule

>>> rtl/core/nnsag_stepper.sv
// shared error stepper: one subtract/compare and one position adder for both axes
module nnsag_stepper #(
  parameter int ADDR_BITS   = nnsag_pkg::DEF_ADDR_BITS,
  parameter int MAX_SRC_DIM = nnsag_pkg::DEF_MAX_SRC_DIM,
  parameter int MAX_DST_DIM = nnsag_pkg::DEF_MAX_DST_DIM
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  nnsag_pkg::step_cmd_t                   cmd,
  input  logic [$clog2(MAX_SRC_DIM+1)-1:0]       src_w,
  input  logic [$clog2(MAX_SRC_DIM+1)-1:0]       src_h,
  input  logic [$clog2(MAX_DST_DIM+1)-1:0]       dst_w,
  input  logic [$clog2(MAX_DST_DIM+1)-1:0]       dst_h,
  input  logic [nnsag_pkg::STRIDE_REG_W-1:0]     stride,
  output logic [ADDR_BITS-1:0]                   src_col,
  output logic [ADDR_BITS-1:0]                   src_row_base,
  output logic                                   done
);

  localparam int EW = $clog2(MAX_DST_DIM + MAX_SRC_DIM);

  logic [EW-1:0]        x_err_r, x_err_nxt;
  logic [EW-1:0]        y_err_r, y_err_nxt;
  logic [ADDR_BITS-1:0] col_r, col_nxt;
  logic [ADDR_BITS-1:0] row_base_r, row_base_nxt;
  logic                 axis_y_r, axis_y_nxt;

  logic [EW-1:0]        x_base, y_base;
  logic [ADDR_BITS-1:0] col_base, rb_base;
  logic [EW-1:0]        sel_err, divisor, diff;
  logic                 ge;
  logic [ADDR_BITS-1:0] pos, pos_inc, pos_sum;

  // starting values, zeroed when the frame restarts on the same word
  assign x_base   = cmd.clear ? '0 : x_err_r;
  assign y_base   = cmd.clear ? '0 : y_err_r;
  assign col_base = cmd.clear ? '0 : col_r;
  assign rb_base  = cmd.clear ? '0 : row_base_r;

  // shared compare and subtract
  assign sel_err = axis_y_r ? y_err_r : x_err_r;
  assign divisor = axis_y_r ? EW'(dst_h) : EW'(dst_w);
  assign ge      = sel_err >= divisor;
  assign diff    = sel_err - divisor;

  // shared position adder: next column or next source row
  assign pos     = axis_y_r ? row_base_r : col_r;
  assign pos_inc = axis_y_r ? ADDR_BITS'(stride) : ADDR_BITS'(1);
  assign pos_sum = pos + pos_inc;

  assign done = cmd.run && !ge;

  // next state of the steppers
  always_comb begin
    x_err_nxt    = x_err_r;
    y_err_nxt    = y_err_r;
    col_nxt      = col_r;
    row_base_nxt = row_base_r;
    axis_y_nxt   = axis_y_r;
    if (cmd.start) begin
      axis_y_nxt = cmd.axis_y;
      if (cmd.axis_y) begin
        x_err_nxt    = '0;
        col_nxt      = '0;
        y_err_nxt    = y_base + EW'(src_h);
        row_base_nxt = rb_base;
      end else begin
        x_err_nxt    = x_base + EW'(src_w);
        col_nxt      = col_base;
        y_err_nxt    = y_base;
        row_base_nxt = rb_base;
      end
    end else if (cmd.clear) begin
      x_err_nxt    = '0;
      y_err_nxt    = '0;
      col_nxt      = '0;
      row_base_nxt = '0;
    end else if (cmd.run && ge) begin
      if (axis_y_r) begin
        y_err_nxt    = diff;
        row_base_nxt = pos_sum;
      end else begin
        x_err_nxt = diff;
        col_nxt   = pos_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_err_r    <= '0;
      y_err_r    <= '0;
      col_r      <= '0;
      row_base_r <= '0;
      axis_y_r   <= 1'b0;
    end else begin
      x_err_r    <= x_err_nxt;
      y_err_r    <= y_err_nxt;
      col_r      <= col_nxt;
      row_base_r <= row_base_nxt;
      axis_y_r   <= axis_y_nxt;
    end
  end

  assign src_col      = col_r;
  assign src_row_base = row_base_r;

`ifndef NO_ASSERTIONS
  // a horizontal step that subtracts lowers the horizontal error by exactly the divisor
  a_step_sub: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.run && ge && !cmd.start && !cmd.clear && !axis_y_r)
      |=> (x_err_r == $past(diff)))
    else $error("horizontal error did not drop by the divisor");

  // horizontal steps leave the vertical error untouched
  a_y_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.run && !axis_y_r && !cmd.start && !cmd.clear) |=> $stable(y_err_r))
    else $error("vertical error changed during horizontal stepping");

  // a clear without start zeroes all positions
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.clear && !cmd.start) |=> (col_r == '0 && row_base_r == '0))
    else $error("stepper positions not cleared");
`endif

endmodule
